FILE: rtl/scj_pkg.sv
// ============================================================================
// scj_pkg
// Shared types and codes of the settings change journal.
// ============================================================================
package scj_pkg;

    localparam int STAMP_W = 31;
    localparam int INDEX_W = 8;
    localparam int VALUE_W = 64;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_SEEK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] after;
        logic [VALUE_W-1:0] prior;
        logic [INDEX_W-1:0] index;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               kind;
        logic               status;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

FILE: rtl/scj_log_ram.sv
// ============================================================================
// scj_log_ram
// Journal entry store: one write port, one read port, registered read data.
// ============================================================================
module scj_log_ram
    import scj_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/settings_change_journal_unit.sv
// ============================================================================
// settings_change_journal_unit
// Journal of setting changes with a replay cursor and undo/redo walk.
// ============================================================================
//  channel  ports                         request
//  s_*      tvalid tready tdata tuser     push, seek or clear
//  m_*      tvalid tready tdata tuser     acknowledge or apply result
//                 tlast
//
//  Push, clear, spare codes: the acknowledge shows the cycle after the request.
//  Seek: the request cycle, one walked entry per cycle while not stalled,
//  one check step for each walk direction that stops short of the log edge,
//  and one closing step; a seek with cursor and fill both zero answers at once.
//  A result held in the output register stalls the walk until m_tready takes it; no new
//  request is taken until a seek has delivered its last result.
//  Reset empties the journal at once; entries are not cleared.
// ============================================================================
module settings_change_journal_unit
    import scj_pkg::*;
#(
    parameter int JOURNAL_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,   // iteration, setting_index, old_value, new_value, pad
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // apply_index, apply_value
    output logic [1:0]   m_tuser,   // kind, status
    output logic         m_tlast
);

    localparam int ADDR_W = $clog2(JOURNAL_DEPTH);
    localparam int CNT_W  = $clog2(JOURNAL_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BACK = 2'd1;
    localparam logic [1:0] ST_FWD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam result_t ACK = '{kind: 1'b0, status: 1'b0, index: '0, value: '0};

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   cursor_reg, cursor_next;
    logic [STAMP_W-1:0] target_reg, target_next;
    result_t            hold_reg, hold_next;
    logic               hold_valid_reg, hold_valid_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;
    logic               out_valid_reg, out_valid_next;

    logic               can_emit;
    logic               in_req;
    entry_t             in_entry;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    entry_t             rd_data;
    logic [CNT_W-1:0]   cursor_dec;
    logic [CNT_W-1:0]   cursor_dec2;
    logic [CNT_W-1:0]   cursor_inc;

    assign can_emit    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) && can_emit;
    assign in_req      = s_tvalid && s_tready;
    assign in_entry    = entry_t'(s_tdata[ENTRY_W-1:0]);
    assign cursor_dec  = cursor_reg - CNT_W'(1);
    assign cursor_dec2 = cursor_reg - CNT_W'(2);
    assign cursor_inc  = cursor_reg + CNT_W'(1);
    assign wr_en       = in_req && (s_tuser == FUNC_PUSH)
                         && (fill_reg != CNT_W'(JOURNAL_DEPTH));

    scj_log_ram #(
        .DEPTH  (JOURNAL_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cursor_next     = cursor_reg;
        target_next     = target_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        rd_en           = 1'b0;
        rd_addr         = cursor_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    out_next       = ACK;
                    out_last_next  = 1'b1;
                    case (s_tuser)
                        FUNC_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (fill_reg == CNT_W'(JOURNAL_DEPTH))
                            begin
                                out_next.status = 1'b1;
                            end
                            else
                            begin
                                fill_next   = fill_reg + CNT_W'(1);
                                cursor_next = fill_reg + CNT_W'(1);
                            end
                        end
                        FUNC_SEEK:
                        begin
                            target_next     = in_entry.stamp;
                            hold_valid_next = 1'b0;
                            if (cursor_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cursor_dec[ADDR_W-1:0];
                                state_next = ST_BACK;
                            end
                            else if (cursor_reg < fill_reg)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_FWD;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            fill_next      = '0;
                            cursor_next    = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BACK:
            begin
                if (rd_data.stamp > target_reg)
                begin
                    if (can_emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next       = '{kind: 1'b1, status: 1'b0,
                                            index: rd_data.index, value: rd_data.prior};
                        hold_valid_next = 1'b1;
                        cursor_next     = cursor_dec;
                        if (cursor_dec != '0)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = cursor_dec2[ADDR_W-1:0];
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
                else if (hold_valid_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (cursor_reg < fill_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_FWD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FWD:
            begin
                if (rd_data.stamp <= target_reg)
                begin
                    if (can_emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next       = '{kind: 1'b1, status: 1'b0,
                                            index: rd_data.index, value: rd_data.after};
                        hold_valid_next = 1'b1;
                        cursor_next     = cursor_inc;
                        if (cursor_inc < fill_reg)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = cursor_inc[ADDR_W-1:0];
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (can_emit)
                begin
                    out_next        = hold_valid_reg ? hold_reg : ACK;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            cursor_reg     <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            cursor_reg     <= cursor_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.value, out_reg.index};
    assign m_tuser  = {out_reg.status, out_reg.kind};
    assign m_tlast  = out_last_reg;

    a_cursor_in_log: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= fill_reg)
        else $error("cursor beyond journal fill");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(JOURNAL_DEPTH))
        else $error("journal fill beyond depth");

    a_fwd_in_log: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FWD |-> cursor_reg < fill_reg)
        else $error("forward walk reads past journal end");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE)
        else $error("request taken during a walk");

endmodule

FILE: verif/tb_settings_change_journal_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_settings_change_journal_unit
// Self-checking bench for the settings change journal. Pushes, seeks, clears
// and spare requests go in over the slave stream. A predictor replays each
// accepted request against its own copy of the log and cursor. Every result
// on the master stream is checked field by field against the oldest
// prediction. Both streams idle at random, and the output is held off once
// for a long stretch.
// ============================================================================
module tb_settings_change_journal_unit
    import scj_pkg::*;
();

    localparam int                 DEPTH      = 64;
    localparam logic [1:0]         FUNC_SPARE = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;

    typedef struct {
        logic [1:0]         func;
        logic [STAMP_W-1:0] iteration;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] prior;
        logic [VALUE_W-1:0] after;
    } request_t;

    typedef struct {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               last;
    } outcome_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    logic [STAMP_W-1:0] log_stamp_m  [DEPTH];
    logic [INDEX_W-1:0] log_index_m  [DEPTH];
    logic [VALUE_W-1:0] log_before_m [DEPTH];
    logic [VALUE_W-1:0] log_after_m  [DEPTH];
    int unsigned        fill_m;
    int unsigned        cursor_m;
    outcome_t           pending_results[$];

    bit no_idle;
    bit hold_output;
    int failures;
    int n_requests;
    int n_pushes;
    int n_seeks;
    int n_clears;
    int n_spare;
    int n_results;
    int n_applies;
    int n_drops;
    int longest_walk;

    settings_change_journal_unit #(
        .JOURNAL_DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic outcome_t make_outcome(logic kind, logic [INDEX_W-1:0] index,
                                              logic [VALUE_W-1:0] value, logic status);
        outcome_t o;
        o.kind   = kind;
        o.index  = index;
        o.value  = value;
        o.status = status;
        o.last   = 1'b0;
        return o;
    endfunction

    function automatic void replay_journal(request_t r);
        outcome_t batch[$];
        case (r.func)
            FUNC_PUSH:
            begin
                if (fill_m >= DEPTH)
                begin
                    batch = {batch, make_outcome(1'b0, '0, '0, 1'b1)};
                    n_drops++;
                end
                else
                begin
                    log_stamp_m[fill_m]  = r.iteration;
                    log_index_m[fill_m]  = r.index;
                    log_before_m[fill_m] = r.prior;
                    log_after_m[fill_m]  = r.after;
                    fill_m++;
                    cursor_m = fill_m;
                    batch = {batch, make_outcome(1'b0, '0, '0, 1'b0)};
                end
            end
            FUNC_SEEK:
            begin
                while (cursor_m > 0 && batch.size() < DEPTH &&
                       log_stamp_m[cursor_m-1] > r.iteration)
                begin
                    cursor_m--;
                    batch = {batch, make_outcome(1'b1, log_index_m[cursor_m],
                                                 log_before_m[cursor_m], 1'b0)};
                end
                while (cursor_m < fill_m && batch.size() < DEPTH &&
                       log_stamp_m[cursor_m] <= r.iteration)
                begin
                    batch = {batch, make_outcome(1'b1, log_index_m[cursor_m],
                                                 log_after_m[cursor_m], 1'b0)};
                    cursor_m++;
                end
                n_applies += batch.size();
                if (batch.size() > longest_walk)
                    longest_walk = batch.size();
                if (batch.size() == 0)
                    batch = {batch, make_outcome(1'b0, '0, '0, 1'b0)};
            end
            FUNC_CLEAR:
            begin
                fill_m   = 0;
                cursor_m = 0;
                batch = {batch, make_outcome(1'b0, '0, '0, 1'b0)};
            end
            default:
            begin
                batch = {batch, make_outcome(1'b0, '0, '0, 1'b0)};
            end
        endcase
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            pending_results = {pending_results, batch[i]};
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.after, r.prior, r.index, r.iteration};
        s_tuser  <= r.func;
        do
            @(posedge clk);
        while (!s_tready);
        replay_journal(r);
        n_requests++;
        case (r.func)
            FUNC_PUSH:  n_pushes++;
            FUNC_SEEK:  n_seeks++;
            FUNC_CLEAR: n_clears++;
            default:    n_spare++;
        endcase
        @(negedge clk);
    endtask

    function automatic request_t build_request(logic [1:0] func, logic [STAMP_W-1:0] iteration);
        request_t r;
        r.func      = func;
        r.iteration = iteration;
        r.index     = INDEX_W'($urandom_range(0, 255));
        r.prior     = {$urandom, $urandom};
        r.after     = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send_push(logic [STAMP_W-1:0] stamp, logic [INDEX_W-1:0] index,
                             logic [VALUE_W-1:0] prior, logic [VALUE_W-1:0] after);
        request_t r;
        r.func      = FUNC_PUSH;
        r.iteration = stamp;
        r.index     = index;
        r.prior     = prior;
        r.after     = after;
        send_request(r);
    endtask

    task automatic send_seek(logic [STAMP_W-1:0] target);
        send_request(build_request(FUNC_SEEK, target));
    endtask

    task automatic send_clear();
        send_request(build_request(FUNC_CLEAR, STAMP_W'($urandom)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic report_field(string name, logic [VALUE_W-1:0] expected_value,
                                logic [VALUE_W-1:0] actual_value);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, expected_value, actual_value);
        failures++;
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d value 0x%0h",
                         $time, m_tuser[0], m_tdata[71:8]);
                failures++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser[0] !== e.kind)
                    report_field("kind", VALUE_W'(e.kind), VALUE_W'(m_tuser[0]));
                if (m_tuser[1] !== e.status)
                    report_field("status", VALUE_W'(e.status), VALUE_W'(m_tuser[1]));
                if (m_tdata[7:0] !== e.index)
                    report_field("apply_index", VALUE_W'(e.index), VALUE_W'(m_tdata[7:0]));
                if (m_tdata[71:8] !== e.value)
                    report_field("apply_value", e.value, m_tdata[71:8]);
                if (m_tlast !== e.last)
                    report_field("last", VALUE_W'(e.last), VALUE_W'(m_tlast));
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_output)
            begin
                stall       = 400;
                hold_output = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    task automatic test_empty_journal();
        send_seek('0);
        send_seek(STAMP_MAX);
        send_clear();
        send_request(build_request(FUNC_SPARE, STAMP_W'($urandom)));
        wait_drained();
    endtask

    task automatic test_walk_directed();
        send_push('0, 8'h00, '0, '1);
        send_push(31'd5, 8'hFF, '1, '0);
        send_push(STAMP_MAX, 8'h5A, {$urandom, $urandom}, {$urandom, $urandom});
        send_seek(STAMP_MAX);
        send_seek('0);
        send_seek(31'd4);
        send_seek(31'd5);
        send_seek(STAMP_MAX);
        send_seek('0);
        send_request(build_request(FUNC_SPARE, STAMP_W'($urandom)));
        send_push(31'd3, 8'hA5, {$urandom, $urandom}, {$urandom, $urandom});
        send_seek(31'd4);
        send_seek(31'd2);
        send_seek(STAMP_MAX);
        send_clear();
        send_seek(STAMP_MAX);
        wait_drained();
    endtask

    task automatic test_journal_full();
        logic [STAMP_W-1:0] stamp;
        stamp = STAMP_W'($urandom_range(0, 32'h7FFF_0000));
        send_clear();
        no_idle = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            send_request(build_request(FUNC_PUSH, stamp));
            stamp = STAMP_W'(stamp + $urandom_range(0, 3));
        end
        no_idle = 1'b0;
        send_request(build_request(FUNC_PUSH, stamp));
        send_request(build_request(FUNC_PUSH, STAMP_W'($urandom)));
        send_seek('0);
        send_seek(STAMP_MAX);
        send_request(build_request(FUNC_PUSH, stamp));
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        logic [STAMP_W-1:0] stamp;
        stamp = STAMP_W'($urandom_range(0, 1000));
        send_clear();
        hold_output = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 5 == 4)
                send_seek(STAMP_W'(stamp - $urandom_range(0, 8)));
            else
                send_request(build_request(FUNC_PUSH, stamp));
            stamp = STAMP_W'(stamp + $urandom_range(0, 2));
        end
        wait_drained();
    endtask

    task automatic test_random_sessions(int target_requests);
        logic [STAMP_W-1:0] base;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] target;
        int                 pushes;
        while (n_requests < target_requests)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_request(build_request(2'($urandom_range(0, 3)),
                                               STAMP_W'($urandom)));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       base = STAMP_W'($urandom_range(0, 20));
                    1:       base = STAMP_MAX - STAMP_W'(300);
                    default: base = STAMP_W'($urandom_range(0, 32'h7FFF_0000));
                endcase
                if ($urandom_range(0, 2) != 0)
                    send_clear();
                pushes = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70)
                                                     : $urandom_range(1, 20);
                no_idle = ($urandom_range(0, 5) == 0);
                stamp   = base;
                lo      = (base > STAMP_W'(2)) ? base - STAMP_W'(2) : '0;
                for (int i = 0; i < pushes; i++)
                begin
                    send_request(build_request(FUNC_PUSH, stamp));
                    stamp = STAMP_W'(stamp + $urandom_range(0, 3));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        case ($urandom_range(0, 7))
                            0:       target = '0;
                            1:       target = STAMP_MAX;
                            default: target = STAMP_W'(lo + $urandom_range(0, stamp - lo + 2));
                        endcase
                        send_seek(target);
                    end
                end
                repeat ($urandom_range(1, 4))
                    send_seek(STAMP_W'(lo + $urandom_range(0, stamp - lo + 2)));
                no_idle = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin : timeout_guard
        #(100_000_000);
        $display("settings_change_journal_unit test failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = FUNC_PUSH;
        no_idle      = 1'b0;
        hold_output  = 1'b0;
        failures     = 0;
        n_requests   = 0;
        n_pushes     = 0;
        n_seeks      = 0;
        n_clears     = 0;
        n_spare      = 0;
        n_results    = 0;
        n_applies    = 0;
        n_drops      = 0;
        longest_walk = 0;
        fill_m       = 0;
        cursor_m     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_journal();
        test_walk_directed();
        test_journal_full();
        test_output_hold_off();
        test_random_sessions(380);

        $display("Covered %0d requests: %0d pushes, %0d seeks, %0d clears, %0d spare",
                 n_requests, n_pushes, n_seeks, n_clears, n_spare);
        $display("Checked %0d results: %0d applies, %0d dropped pushes, longest walk %0d",
                 n_results, n_applies, n_drops, longest_walk);
        if (failures == 0)
            $display("settings_change_journal_unit test passed");
        else
            $display("settings_change_journal_unit test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/scj_pkg.sv
rtl/scj_log_ram.sv
rtl/settings_change_journal_unit.sv
verif/tb_settings_change_journal_unit.sv
